// File: hdl/rcbm_pkg.sv
// Shared types and constants of the region checked byte memory.
package rcbm_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_W    = 3;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned ROW_W     = 13;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [2:0] {
    SCOPE_CODE  = 3'd0,
    SCOPE_DATA  = 3'd1,
    SCOPE_HEAP  = 3'd2,
    SCOPE_STACK = 3'd3,
    SCOPE_PTR   = 3'd4,
    SCOPE_ANY   = 3'd5
  } scope_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2
  } size_e;

  localparam logic FUNC_WRITE     = 1'b1;
  localparam logic REG_DATA_START = 1'b0;

  typedef struct packed {
    logic              func;
    logic [1:0]        access_size;
    logic [2:0]        scope;
    logic [ADDR_W-1:0] address;
    logic [63:0]       write_data;
    logic [ADDR_W-1:0] heap_base;
    logic [ADDR_W-1:0] heap_top;
    logic [ADDR_W-1:0] stack_pointer;
  } in_word_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        region_error;
  } out_word_t;

  // classified access: shared flags and base lane, with enable, row and write byte per lane
  typedef struct packed {
    logic                         wr;
    logic                         err;
    logic [LANE_W-1:0]            base_lane;
    logic [LANES-1:0]             lane_en;
    logic [LANES-1:0][ROW_W-1:0]  row;
    logic [LANES-1:0][7:0]        wbyte;
  } op_t;

endpackage

// File: hdl/rcbm_fifo.sv
// Small register queue with push/full and pop/empty sides.
module rcbm_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH+1);

  T                store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/rcbm_front.sv
// Front end: region check and byte lane split of an incoming access word.
module rcbm_front #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic [15:0]         data_start_i,
  input  rcbm_pkg::in_word_t  word_i,
  output rcbm_pkg::op_t       op_o
);
  import rcbm_pkg::*;

  localparam logic [ROW_W-1:0] PageRowMask = ROW_W'(PAGE_BYTES/8 - 1);

  logic              in_code, in_data, in_heap, in_stack, ok;
  logic [LANE_W-1:0] pos;
  logic [ROW_W-1:0]  row_base, row_next, row_wrap;

  always_comb begin
    in_code  = word_i.address < data_start_i;
    in_data  = !in_code && (word_i.address < word_i.heap_base);
    in_heap  = (word_i.address >= word_i.heap_base) && (word_i.address <= word_i.heap_top);
    in_stack = word_i.address >= word_i.stack_pointer;
    case (word_i.scope)
      SCOPE_CODE:  ok = in_code;
      SCOPE_DATA:  ok = in_data;
      SCOPE_HEAP:  ok = in_heap;
      SCOPE_STACK: ok = in_stack;
      SCOPE_PTR:   ok = in_data || in_heap;
      SCOPE_ANY:   ok = 1'b1;
      default:     ok = 1'b0;
    endcase
  end

  assign row_base = word_i.address[ADDR_W-1:LANE_W];
  assign row_next = row_base + ROW_W'(1);
  // next row, wrapped inside the page
  assign row_wrap = (row_base & ~PageRowMask) | (row_next & PageRowMask);

  always_comb begin
    pos            = '0;
    op_o.wr        = (word_i.func == FUNC_WRITE);
    op_o.err       = !ok;
    op_o.base_lane = word_i.address[LANE_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      pos = LANE_W'(l) - word_i.address[LANE_W-1:0];
      case (word_i.access_size)
        SIZE_BYTE: op_o.lane_en[l] = (pos == '0);
        SIZE_WORD: op_o.lane_en[l] = (pos < LANE_W'(4));
        default:   op_o.lane_en[l] = 1'b1;
      endcase
      op_o.row[l]   = (LANE_W'(l) < word_i.address[LANE_W-1:0]) ? row_wrap : row_base;
      op_o.wbyte[l] = word_i.write_data[{pos, 3'b000} +: 8];
    end
  end

endmodule

// File: hdl/rcbm_back.sv
// Back end: byte lane banks, clear sweep after reset and read word assembly.
module rcbm_back #(
  parameter int unsigned MEM_BYTES = 65536,
  parameter int unsigned CNT_W     = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  rcbm_pkg::op_t         op_i,
  output logic                  op_pop_o,
  input  logic [CNT_W-1:0]      res_count_i,
  output logic                  res_push_o,
  output rcbm_pkg::out_word_t   res_o,
  output logic                  clearing_o
);
  import rcbm_pkg::*;

  localparam int unsigned Rows = MEM_BYTES / LANES;
  localparam int unsigned RowW = $clog2(Rows);

  typedef struct packed {
    logic              wr;
    logic              err;
    logic [LANE_W-1:0] base_lane;
    logic [LANES-1:0]  lane_en;
  } meta_t;

  logic                       clr_q, clr_d;
  logic [RowW-1:0]            clr_row_q, clr_row_d;
  logic                       valid_q;
  meta_t                      meta_q;
  logic                       issue;
  logic [LANES-1:0]           bank_we;
  logic [LANES-1:0][RowW-1:0] bank_addr;
  logic [LANES-1:0][7:0]      bank_wd;
  logic [7:0]                 bank_rd [LANES];
  logic [31:0]                row_wide [LANES];
  logic [LANE_W-1:0]          lane;

  assign issue      = op_valid_i && !clr_q &&
                      ((32'(res_count_i) + 32'(valid_q)) < RES_DEPTH);
  assign op_pop_o   = issue;
  assign clearing_o = clr_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      row_wide[l]  = 32'(op_i.row[l]);
      bank_addr[l] = clr_q ? clr_row_q : row_wide[l][RowW-1:0];
      bank_we[l]   = clr_q || (issue && op_i.wr && op_i.lane_en[l]);
      bank_wd[l]   = clr_q ? 8'h00 : op_i.wbyte[l];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    logic [7:0] mem [Rows];
    always_ff @(posedge clk_i) begin
      if (bank_we[g]) begin
        mem[bank_addr[g]] <= bank_wd[g];
      end
      bank_rd[g] <= mem[bank_addr[g]];
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      clr_row_d = clr_row_q + RowW'(1);
      if (clr_row_q == RowW'(Rows-1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_row_q <= clr_row_d;
      valid_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      meta_q <= '{wr: op_i.wr, err: op_i.err, base_lane: op_i.base_lane,
                  lane_en: op_i.lane_en};
    end
  end

  always_comb begin
    lane                = '0;
    res_o.region_error  = meta_q.err;
    res_o.read_data     = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = meta_q.base_lane + LANE_W'(i);
      if (!meta_q.wr && meta_q.lane_en[lane]) begin
        res_o.read_data[8*i +: 8] = bank_rd[lane];
      end
    end
  end

  assign res_push_o = valid_q;

endmodule

// File: hdl/region_checked_byte_memory_unit.sv
// Region checked byte memory: top level with config register and queues.
//
// Usage:
//   Access words enter on in_word_i with push/full and leave on out_word_o
//   with empty/pop. Every access word yields exactly one result word, in order.
//   data_start is written over the APB port at byte address 0 and reads back.
//   Store is MEM_BYTES bytes in eight byte-lane banks; multi-byte accesses
//   wrap inside the PAGE_BYTES page of the first address.
// Timing:
//   An accepted word passes the command queue, the bank read register and the
//   result queue to reach out_word_o. Throughput is one word per cycle unless
//   the back end waits for result queue room, set by the single port of each bank.
// Reset:
//   After reset the banks are swept to zero, one row of eight bytes per cycle,
//   MEM_BYTES/8 rows in all (8192 by default); full stays high meanwhile.
// Back pressure:
//   While pop is low, results collect in a four-word queue; the back end stops
//   issuing when queued plus in-flight results reach four, and full rises once the command queue fills.
module region_checked_byte_memory_unit #(
  parameter int unsigned MEM_BYTES  = 65536,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  rcbm_pkg::in_word_t   in_word_i,
  output logic                 empty,
  input  logic                 pop,
  output rcbm_pkg::out_word_t  out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rcbm_pkg::*;

  localparam int unsigned ResCntW = $clog2(RES_DEPTH+1);

  logic [15:0]        data_start_q;
  op_t                front_op, cmd_op;
  logic               cmd_full, cmd_empty, cmd_pop;
  logic               clearing;
  logic               res_push;
  out_word_t          res_word;
  logic [ResCntW-1:0] res_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DATA_START) ? {16'h0000, data_start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DATA_START)) begin
      data_start_q <= pwdata[15:0];
    end
  end

  assign full = cmd_full || clearing;

  rcbm_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .data_start_i(data_start_q),
    .word_i      (in_word_i),
    .op_o        (front_op)
  );

  rcbm_fifo #(
    .DEPTH(CMD_DEPTH),
    .T    (op_t)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !clearing),
    .data_i (front_op),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_op),
    .empty_o(cmd_empty),
    .count_o()
  );

  rcbm_back #(
    .MEM_BYTES(MEM_BYTES),
    .CNT_W    (ResCntW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!cmd_empty),
    .op_i       (cmd_op),
    .op_pop_o   (cmd_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_word),
    .clearing_o (clearing)
  );

  rcbm_fifo #(
    .DEPTH(RES_DEPTH),
    .T    (out_word_t)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word),
    .full_o (),
    .pop_i  (pop),
    .data_o (out_word_o),
    .empty_o(empty),
    .count_o(res_count)
  );

endmodule

// File: hdl/rcbm_checker.sv
// Port level checks of the region checked byte memory, bound to the top level.
module rcbm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input rcbm_pkg::out_word_t  out_word_o,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [2:0]           paddr,
  input logic [31:0]          pwdata,
  input logic [31:0]          prdata,
  input logic                 pready
);
  import rcbm_pkg::*;

  logic [15:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 16'(push && !full) - 16'(pop && !empty);
    end
  end

  // a result word only follows an accepted access word
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != '0)
    else $error("result word without a pending access");

  // a waiting result word holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("result word changed while waiting");

  // data_start reads back what was written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == REG_DATA_START)) |=>
    (!(psel && !pwrite && (paddr[2] == REG_DATA_START)) ||
     (prdata == {16'h0000, $past(pwdata[15:0])})))
    else $error("data_start read back mismatch");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("config port stalled");

endmodule

bind region_checked_byte_memory_unit rcbm_checker u_rcbm_checker (.*);

// File: test/tb_region_checked_byte_memory_unit.sv
// Self-checking testbench: random and directed accesses against a byte-store predictor.
module tb_region_checked_byte_memory_unit;
  import rcbm_pkg::*;

  localparam int unsigned MEM_SIZE    = 65536;
  localparam int unsigned PAGE_LEN    = 4096;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned PHASE_WORDS = 350;
  localparam logic        FUNC_READ   = 1'b0;
  localparam logic [2:0]  SCOPE_BAD6  = 3'd6;
  localparam logic [2:0]  SCOPE_BAD7  = 3'd7;
  localparam logic [1:0]  SIZE_RSVD   = 2'd3;
  localparam logic [2:0]  DATA_START_ADDR = 3'(4 * REG_DATA_START);

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        full;
  in_word_t    in_word = '0;
  logic        empty;
  logic        pop     = 1'b0;
  out_word_t   out_word;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  shadow_mem [0:MEM_SIZE-1];
  logic [15:0] data_start_cfg = '0;
  in_word_t    access_queue[$];
  out_word_t   expected_words[$];
  out_word_t   want_word;
  int unsigned mismatches     = 0;
  int unsigned accepted_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_count    = 0;
  int unsigned pop_odds       = 4;
  logic        long_hold      = 1'b0;

  region_checked_byte_memory_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 20) $display("ERROR @%0t: %s", $time, what);
  endtask

  // performs one access on the shadow store, returns the result word
  function automatic out_word_t apply_access(in_word_t w);
    out_word_t   r;
    int unsigned nbytes;
    int unsigned offset;
    int unsigned page_base;
    int unsigned idx;
    logic        in_code;
    logic        in_data;
    logic        in_heap;
    logic        in_stack;
    logic        ok;
    r = '0;
    case (w.access_size)
      SIZE_BYTE: nbytes = 1;
      SIZE_WORD: nbytes = 4;
      default:   nbytes = 8;
    endcase
    offset    = w.address % PAGE_LEN;
    page_base = w.address - offset;
    for (int unsigned i = 0; i < nbytes; i++) begin
      idx = (page_base + (offset + i) % PAGE_LEN) % MEM_SIZE;
      if (w.func == FUNC_WRITE) begin
        shadow_mem[idx] = w.write_data[8*i +: 8];
      end else begin
        r.read_data[8*i +: 8] = shadow_mem[idx];
      end
    end
    in_code  = w.address < data_start_cfg;
    in_data  = (w.address >= data_start_cfg) && (w.address < w.heap_base);
    in_heap  = (w.address >= w.heap_base) && (w.address <= w.heap_top);
    in_stack = w.address >= w.stack_pointer;
    case (w.scope)
      SCOPE_CODE:  ok = in_code;
      SCOPE_DATA:  ok = in_data;
      SCOPE_HEAP:  ok = in_heap;
      SCOPE_STACK: ok = in_stack;
      SCOPE_PTR:   ok = in_data || in_heap;
      SCOPE_ANY:   ok = 1'b1;
      default:     ok = 1'b0;
    endcase
    r.region_error = !ok;
    return r;
  endfunction

  task automatic queue_access(logic f, logic [1:0] sz, logic [2:0] sc, logic [15:0] a,
                              logic [63:0] wd, logic [15:0] hb, logic [15:0] hp,
                              logic [15:0] sp);
    in_word_t w;
    w.func          = f;
    w.access_size   = sz;
    w.scope         = sc;
    w.address       = a;
    w.write_data    = wd;
    w.heap_base     = hb;
    w.heap_top      = hp;
    w.stack_pointer = sp;
    access_queue.push_back(w);
  endtask

  function automatic in_word_t random_access();
    in_word_t    w;
    logic [15:0] a;
    case ($urandom_range(0, 3))
      0: a = {4'($urandom), 12'hFFF} - 16'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: a = 16'h0000;
          1: a = 16'h0FF8;
          2: a = 16'h8000;
          default: a = 16'hFFE0;
        endcase
        a = a + 16'($urandom_range(0, 31));
      end
      2: a = data_start_cfg + 16'($urandom_range(0, 15)) - 16'd8;
      default: a = 16'($urandom);
    endcase
    w.func        = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
    w.access_size = 2'($urandom_range(0, 3));
    w.scope       = 3'($urandom_range(0, 7));
    w.address     = a;
    w.write_data  = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      w.heap_base     = a + 16'($urandom_range(0, 4)) - 16'd2;
      w.heap_top      = a + 16'($urandom_range(0, 4)) - 16'd2;
      w.stack_pointer = a + 16'($urandom_range(0, 4)) - 16'd2;
    end else begin
      w.heap_base     = 16'($urandom);
      w.heap_top      = 16'($urandom);
      w.stack_pointer = 16'($urandom);
    end
    return w;
  endfunction

  // write over APB, then read back
  task automatic write_data_start(logic [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DATA_START_ADDR;
    pwdata  <= {16'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel           <= 1'b0;
    penable        <= 1'b0;
    data_start_cfg  = v;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== {16'h0, v})
      report_mismatch($sformatf("data_start readback got %h want %h", prdata, v));
  endtask

  task automatic settle();
    while (access_queue.size() != 0 || push || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("region_checked_byte_memory_unit: mismatch");
      $finish;
    end
  end

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_words.push_back(apply_access(in_word));
        accepted_count++;
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (access_queue.size() == 0) begin
          push <= 1'b0;
        end else begin
          in_word <= access_queue.pop_front();
          push    <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: checks popped words and pops with a randomly redrawn stall mode
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want_word = expected_words.pop_front();
          if (out_word.read_data !== want_word.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      out_word.read_data, want_word.read_data));
          if (out_word.region_error !== want_word.region_error)
            report_mismatch($sformatf("region_error got %b want %b",
                                      out_word.region_error, want_word.region_error));
        end
      end
      stall_count++;
      if (stall_count % 64 == 0) pop_odds = $urandom_range(1, 4);
      pop <= !long_hold && ($urandom_range(0, 3) < pop_odds);
    end
  end

  // long receiver hold so the block backs up and raises full
  initial begin
    wait (accepted_count >= 500);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    for (int unsigned i = 0; i < MEM_SIZE; i++) shadow_mem[i] = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_data_start(16'h2000);
    queue_access(FUNC_WRITE, SIZE_DWORD, SCOPE_ANY, 16'h0000, 64'h0123456789ABCDEF,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_DWORD, SCOPE_CODE, 16'h0000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    // dword across the page end wraps to the page start
    queue_access(FUNC_WRITE, SIZE_DWORD, SCOPE_DATA, 16'h0FFC, 64'hFEDCBA9876543210,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_DWORD, SCOPE_ANY, 16'h0FFC, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_WORD, SCOPE_ANY, 16'h0000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    // reserved size acts as dword
    queue_access(FUNC_WRITE, SIZE_RSVD, SCOPE_STACK, 16'hFFFA, '1,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_DWORD, SCOPE_STACK, 16'hF000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_STACK, 16'hEFFF, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_WRITE, SIZE_WORD, SCOPE_HEAP, 16'h3000, 64'hFFFFFFFF_A5A55A5A,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_DWORD, SCOPE_HEAP, 16'h3FFF, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_HEAP, 16'h4000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_CODE, 16'h1FFF, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_CODE, 16'h2000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_DATA, 16'h2000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_DATA, 16'h2FFF, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_DATA, 16'h3000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    // inverted heap bounds: empty heap
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_HEAP, 16'h3800, '0,
                 16'h4000, 16'h3000, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_PTR, 16'h2500, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_PTR, 16'h3500, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_PTR, 16'h1000, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_BAD6, 16'h2500, '0,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_WRITE, SIZE_BYTE, SCOPE_BAD7, 16'h5555, 64'hFFFFFFFF_FFFFFF00,
                 16'h3000, 16'h3FFF, 16'hF000);
    queue_access(FUNC_READ, SIZE_BYTE, SCOPE_ANY, 16'h5555, '0,
                 16'hFFFF, 16'h0000, 16'h0000);
    queue_access(FUNC_READ, SIZE_DWORD, SCOPE_ANY, 16'h7777, '0,
                 16'h0000, 16'hFFFF, 16'hFFFF);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_data_start(16'hFFFF);
        1: write_data_start(16'h0000);
        2: write_data_start(16'h4000);
        default: write_data_start(16'($urandom));
      endcase
      repeat (PHASE_WORDS) access_queue.push_back(random_access());
      settle();
    end

    if (mismatches == 0) begin
      $display("region_checked_byte_memory_unit: match");
    end else begin
      $display("region_checked_byte_memory_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rcbm_pkg.sv
hdl/rcbm_fifo.sv
hdl/rcbm_front.sv
hdl/rcbm_back.sv
hdl/region_checked_byte_memory_unit.sv
hdl/rcbm_checker.sv
test/tb_region_checked_byte_memory_unit.sv
